// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define EPCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EPCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/epcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcd_pkg
// Types and constants of the event pixel contrast detector.
// ----------------------------------------------------------------------------
package epcd_pkg;

  localparam int REF_W = 18;
  localparam logic [REF_W-1:0] REF_MAX = 18'h3FFFF;

  localparam logic [15:0] POS_TH_RESET = 16'd19584;
  localparam logic [15:0] NEG_TH_RESET = 16'd39168;

  // configuration register indexes
  localparam logic REG_POS_TH = 1'b0;
  localparam logic REG_NEG_TH = 1'b1;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPARE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] intensity;
    logic [15:0] threshold_jitter;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  event_x;
    logic [7:0]  event_y;
    logic        event_polarity;
    logic [31:0] event_time;
  } out_item_t;

  // outcome of one reference update
  typedef struct packed {
    logic             we;
    logic [REF_W-1:0] wdata;
    logic             emit;
    logic             polarity;
  } ref_update_t;

endpackage

// File: src/epcd_contrast.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcd_contrast
// Reference load, or threshold compare and saturating reference step, for one pixel sample.
// ----------------------------------------------------------------------------
module epcd_contrast import epcd_pkg::*; (
  input  in_item_t         item,
  input  logic [REF_W-1:0] ref_level,
  input  logic [15:0]      pos_threshold,
  input  logic [15:0]      neg_threshold,
  output ref_update_t      upd
);

  logic [REF_W:0]   up_limit;
  logic [REF_W:0]   sample_ext;
  logic [16:0]      down_limit;
  logic [REF_W:0]   up_sum;
  logic [16:0]      down_step;
  logic             rise;
  logic             fall;

  always_comb begin
    sample_ext = (REF_W+1)'(item.intensity);
    up_limit   = (REF_W+1)'(ref_level) + (REF_W+1)'(pos_threshold);
    down_limit = 17'(item.intensity) + 17'(neg_threshold);
    rise       = sample_ext > up_limit;
    fall       = ref_level > REF_W'(down_limit);
    up_sum     = up_limit + (REF_W+1)'(item.threshold_jitter);
    down_step  = 17'(neg_threshold) + 17'(item.threshold_jitter);

    upd = '0;
    if (item.mode == MODE_LOAD) begin
      upd.we    = 1'b1;
      upd.wdata = REF_W'(item.intensity);
    end else if (rise) begin
      upd.we       = 1'b1;
      upd.emit     = 1'b1;
      upd.polarity = 1'b1;
      upd.wdata    = up_sum[REF_W] ? REF_MAX : up_sum[REF_W-1:0];
    end else if (fall) begin
      upd.we       = 1'b1;
      upd.emit     = 1'b1;
      upd.polarity = 1'b0;
      // saturate at zero when the step passes the current level
      upd.wdata    = (REF_W'(down_step) > ref_level) ? '0 : ref_level - REF_W'(down_step);
    end
  end

endmodule

// File: src/event_pixel_contrast_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_pixel_contrast_detector_top
// Per-pixel reference memory with read-modify-write contrast event detection.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_item  (in_item_t)
// out       output     out_valid/out_ready  out_item (out_item_t)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// One sample per cycle while the output is not stalled. A sample is
// registered into stage s1 with its memory read; its event is loaded into
// the output register when s1 commits. The memory has a single read port;
// back-to-back hits on one pixel use a forwarded value.
// Reset clears control and thresholds; the reference memory is not cleared.
// A waiting event holds the sample behind it; the input stalls once that
// sample stage is also occupied.
// ----------------------------------------------------------------------------
module event_pixel_contrast_detector_top import epcd_pkg::*; #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [REF_W-1:0] ref_mem [DEPTH];

  logic [15:0]      pos_threshold;
  logic [15:0]      neg_threshold;

  logic [31:0]      addr_full;
  logic [ADDR_W-1:0] in_addr;
  logic             in_range;
  logic             in_fire;

  logic             s1_valid;
  in_item_t         s1_item;
  logic [ADDR_W-1:0] s1_addr;
  logic             s1_adv;
  logic [REF_W-1:0] rd_data;
  logic             fwd;
  logic [REF_W-1:0] fwd_data;
  logic [REF_W-1:0] ref_level;
  ref_update_t      upd;
  logic             s1_commit;

  always_comb begin
    addr_full = 32'(in_item.pixel_y) * 32'(IMAGE_WIDTH) + 32'(in_item.pixel_x);
    in_addr   = addr_full[ADDR_W-1:0];
    in_range  = (32'(in_item.pixel_x) < 32'(IMAGE_WIDTH)) &&
                (32'(in_item.pixel_y) < 32'(IMAGE_HEIGHT));
  end

  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !rst && (!s1_valid || s1_adv);
  assign in_fire   = in_valid && in_ready;
  assign s1_commit = s1_valid && s1_adv;
  assign ref_level = fwd ? fwd_data : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_threshold <= POS_TH_RESET;
      neg_threshold <= NEG_TH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POS_TH: pos_threshold <= cfg_data;
        REG_NEG_TH: neg_threshold <= cfg_data;
        default:    ;
      endcase
    end
  end

  // reference memory: one read and one write port
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= ref_mem[in_addr];
    end
    if (s1_commit && upd.we) begin
      ref_mem[s1_addr] <= upd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= in_range;
        // the memory write of the committing sample lands on the same edge as this read
        fwd      <= s1_commit && upd.we && (s1_addr == in_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item  <= in_item;
      s1_addr  <= in_addr;
      fwd_data <= upd.wdata;
    end
  end

  epcd_contrast u_contrast (
    .item          (s1_item),
    .ref_level     (ref_level),
    .pos_threshold (pos_threshold),
    .neg_threshold (neg_threshold),
    .upd           (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_commit && upd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit && upd.emit) begin
      out_item.event_x        <= s1_item.pixel_x;
      out_item.event_y        <= s1_item.pixel_y;
      out_item.event_polarity <= upd.polarity;
      out_item.event_time     <= s1_item.timestamp;
    end
  end

endmodule

// File: src/epcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcd_checker
// Port-level checks of the contrast detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epcd_checker import epcd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // an event that is not taken holds
  `EPCD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item), "event changed while stalled")

  // no event right after reset
  `EPCD_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "event present after reset")

  // a fresh event comes from an earlier sample transfer
  `EPCD_ASSERT(a_event_source, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "event without a sample transfer")

  // no sample transfer during reset
  `EPCD_ASSERT_ALWAYS(a_no_rst_xfer, clk, rst |-> !in_ready, "input ready during reset")

endmodule

bind event_pixel_contrast_detector_top epcd_checker u_epcd_checker (.*);
